[rtl/bhpq_pkg.sv]
// Package for the binary heap priority queue: command and status codes.
// No dependencies.
`default_nettype none
package bhpq_pkg;
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

[rtl/bhpq_cmd_fifo.sv]
// Short command queue between the front and the heap engine.
// Depends on nothing but its parameters.
`default_nettype none
module bhpq_cmd_fifo #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      cnt_reg;
    logic             wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // pointer and count update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr_fire)
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            if (rd_fire)
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_fire)
            mem_reg[wptr_reg] <= wr_data;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("fifo count overflow");
    a_no_wr_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_ready |-> !wr_fire) else $error("write while full");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_fire && !rd_fire) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count did not advance");
endmodule
`default_nettype wire

[rtl/bhpq_engine.sv]
// Heap engine: key/payload memory, fill count and the sift sequencer.
// Depends on bhpq_pkg.
`default_nettype none
module bhpq_engine #(
    parameter int CAPACITY      = 256,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int CW            = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     heap_order,
    input  wire logic                     cmd_valid,
    output logic                          cmd_ready,
    input  wire logic                     cmd_op,
    input  wire logic [KEY_WIDTH-1:0]     cmd_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] cmd_payload,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic [1:0]                    res_status,
    output logic [KEY_WIDTH-1:0]          res_out_key,
    output logic [PAYLOAD_WIDTH-1:0]      res_out_payload,
    output logic                          res_top_valid,
    output logic [KEY_WIDTH-1:0]          res_top_key,
    output logic [PAYLOAD_WIDTH-1:0]      res_top_payload,
    output logic [CW-1:0]                 res_total
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_EXT_RD0, S_EXT_RDL, S_EXT_LAST,
        S_DN_RD, S_DN_CMP, S_DN_CMP2, S_TOP_RD, S_TOP, S_OUT
    } state_t;

    logic [EW-1:0] mem_reg [CAPACITY];
    logic [EW-1:0] rdata_reg;

    state_t state_reg;
    logic [CW-1:0] fill_reg;
    logic [AW:0]   idx_reg;      // current hole, wide enough for 2i+1 tests
    logic [AW:0]   child_reg;
    logic [EW-1:0] ent_reg;      // entry being sifted
    logic [EW-1:0] cand_reg;     // left child while right is read
    logic [1:0]    st_reg;
    logic [EW-1:0] got_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    function automatic logic above(input logic ord, input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
        above = ord ? (a < b) : (a > b);
    endfunction

    logic [KEY_WIDTH-1:0] rkey, ekey, ckey;
    logic [AW:0] up_idx, nlast;
    assign rkey   = rdata_reg[EW-1 -: KEY_WIDTH];
    assign ekey   = ent_reg[EW-1 -: KEY_WIDTH];
    assign ckey   = cand_reg[EW-1 -: KEY_WIDTH];
    assign up_idx = (idx_reg - 1'b1) >> 1;
    assign nlast  = (AW+1)'(fill_reg);

    // child pick: right only when it exists and ranks strictly above left
    logic                 pick_right;
    logic                 sift_move;
    logic [KEY_WIDTH-1:0] sel_key;
    logic [EW-1:0]        sel_ent;
    logic [AW:0]          sel_idx;
    assign pick_right = (child_reg + 1'b1 < nlast) && above(heap_order, rkey, ckey);
    assign sel_key    = pick_right ? rkey : ckey;
    assign sel_ent    = pick_right ? rdata_reg : cand_reg;
    assign sel_idx    = pick_right ? child_reg + 1'b1 : child_reg;
    assign sift_move  = above(heap_order, sel_key, ekey);

    assign cmd_ready = (state_reg == S_IDLE);

    // read/write port control
    always_comb begin
        rd_en = 1'b0; rd_addr = '0;
        wr_en = 1'b0; wr_addr = '0; wr_data = ent_reg;
        case (state_reg)
            S_INS_RD: begin rd_en = 1'b1; rd_addr = up_idx[AW-1:0]; end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (idx_reg != '0 && above(heap_order, ekey, rkey)) begin
                    wr_addr = idx_reg[AW-1:0]; wr_data = rdata_reg;
                end else begin
                    wr_addr = idx_reg[AW-1:0]; wr_data = ent_reg;
                end
            end
            S_EXT_RD0: begin rd_en = 1'b1; rd_addr = '0; end
            S_EXT_RDL: begin rd_en = 1'b1; rd_addr = nlast[AW-1:0]; end
            S_DN_RD: begin rd_en = 1'b1; rd_addr = child_reg[AW-1:0]; end
            S_DN_CMP: begin rd_en = 1'b1; rd_addr = AW'(child_reg + 1'b1); end
            S_DN_CMP2: begin
                wr_en = 1'b1; wr_addr = idx_reg[AW-1:0];
                wr_data = sift_move ? sel_ent : ent_reg;
            end
            S_TOP_RD: begin rd_en = 1'b1; rd_addr = '0; end
            default: ;
        endcase
    end

    // memory
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= mem_reg[rd_addr];
    end

    // sift sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            res_valid <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: if (cmd_valid) begin
                    ent_reg <= {cmd_key, cmd_payload};
                    got_reg <= '0;
                    if (cmd_op == CMD_INSERT) begin
                        if (fill_reg >= CW'(CAPACITY)) begin
                            st_reg <= ST_FULL; state_reg <= S_TOP_RD;
                        end else begin
                            st_reg <= ST_DONE;
                            idx_reg <= (AW+1)'(fill_reg);
                            fill_reg <= fill_reg + 1'b1;
                            state_reg <= S_INS_RD;
                        end
                    end else if (fill_reg == '0) begin
                        st_reg <= ST_EMPTY; state_reg <= S_TOP_RD;
                    end else begin
                        st_reg <= ST_DONE;
                        fill_reg <= fill_reg - 1'b1;
                        state_reg <= S_EXT_RD0;
                    end
                end
                S_INS_RD: state_reg <= S_INS_CMP;
                S_INS_CMP: begin
                    if (idx_reg != '0 && above(heap_order, ekey, rkey)) begin
                        idx_reg <= up_idx; state_reg <= S_INS_RD;
                    end else state_reg <= S_TOP_RD;
                end
                S_EXT_RD0: state_reg <= S_EXT_RDL;
                S_EXT_RDL: begin got_reg <= rdata_reg; state_reg <= S_EXT_LAST; end
                S_EXT_LAST: begin
                    ent_reg <= rdata_reg; idx_reg <= '0; child_reg <= (AW+1)'(1);
                    state_reg <= S_DN_RD;
                end
                S_DN_RD: begin
                    // 2i+1 >= n ends the sift; write hole with last entry
                    if (child_reg >= nlast || idx_reg[AW]) begin
                        cand_reg <= ent_reg;  // compare below never moves
                        state_reg <= S_DN_CMP2;
                    end else state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    cand_reg <= rdata_reg;
                    state_reg <= S_DN_CMP2;
                end
                // right child data arrives now; move the picked child up or stop
                S_DN_CMP2: begin
                    if (sift_move) begin
                        idx_reg <= sel_idx;
                        child_reg <= {sel_idx[AW-1:0], 1'b1};
                        state_reg <= S_DN_RD;
                    end else state_reg <= S_TOP_RD;
                end
                S_TOP_RD: state_reg <= S_TOP;
                S_TOP: begin
                    res_valid       <= 1'b1;
                    res_status      <= st_reg;
                    res_out_key     <= got_reg[EW-1 -: KEY_WIDTH];
                    res_out_payload <= got_reg[PAYLOAD_WIDTH-1:0];
                    res_top_valid   <= (fill_reg != '0);
                    res_top_key     <= (fill_reg != '0) ? rkey : '0;
                    res_top_payload <= (fill_reg != '0) ? rdata_reg[PAYLOAD_WIDTH-1:0] : '0;
                    res_total       <= fill_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: if (res_ready) begin
                    res_valid <= 1'b0; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(CAPACITY)) else $error("fill overflow");
    a_res_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> state_reg == S_OUT) else $error("result outside output state");
    a_top_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_top_valid) |-> res_total == '0) else $error("top mismatch");
endmodule
`default_nettype wire

[rtl/binary_heap_priority_queue.sv]
// Top level of the binary heap priority queue: front command queue and engine.
// Depends on bhpq_pkg, bhpq_cmd_fifo, bhpq_engine.
//
//  channel  | dir | contents
//  s_axis   | in  | tdata {new_payload,new_key}, tuser command
//  m_axis   | out | tdata {entry_total,top_payload,top_key,top_valid,out_payload,out_key,status}
//  cfg      | in  | heap_order write
//
// An insert sifts the new entry up level by level and an extract sifts the last entry
// down level by level; the engine takes no new command until its result is accepted.
// Reset clears the fill count; memory contents need no clearing.
// Input items queue in a two-entry buffer while the engine or the result stalls.
`default_nettype none
module binary_heap_priority_queue #(
    parameter int CAPACITY      = 256,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [((KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] s_axis_tdata, // new_key, new_payload
    input  wire logic        s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [143:0]     m_axis_tdata    // status,out_key,out_payload,top_valid,top_key,top_payload,entry_total
);
    import bhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int FW = 1 + KEY_WIDTH + PAYLOAD_WIDTH;

    logic heap_order_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) heap_order_reg <= 1'b0;
        else if (cfg_wr_en) heap_order_reg <= cfg_wr_data;
    end

    logic          q_valid, q_ready;
    logic [FW-1:0] q_data;

    bhpq_cmd_fifo #(.WIDTH(FW), .DEPTH(2)) u_fifo (
        .aclk, .aresetn,
        .wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready),
        .wr_data({s_axis_tuser, s_axis_tdata[KEY_WIDTH-1:0],
                  s_axis_tdata[KEY_WIDTH+PAYLOAD_WIDTH-1:KEY_WIDTH]}),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    logic [1:0] st;
    logic [KEY_WIDTH-1:0] ok, tk;
    logic [PAYLOAD_WIDTH-1:0] op, tp;
    logic tv;
    logic [CW-1:0] tot;

    bhpq_engine #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH),
                  .PAYLOAD_WIDTH(PAYLOAD_WIDTH), .CW(CW)) u_engine (
        .aclk, .aresetn, .heap_order(heap_order_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready),
        .cmd_op(q_data[FW-1]), .cmd_key(q_data[FW-2 -: KEY_WIDTH]),
        .cmd_payload(q_data[PAYLOAD_WIDTH-1:0]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_status(st), .res_out_key(ok), .res_out_payload(op),
        .res_top_valid(tv), .res_top_key(tk), .res_top_payload(tp), .res_total(tot)
    );

    assign m_axis_tdata = {4'd0, 9'(tot), 32'(tp), 32'(tk), tv, 32'(op), 32'(ok), st};
endmodule
`default_nettype wire
